// ----- sv/lobp_pkg.sv -----
// Package for the lexicographic order bounds propagator.
// Word types, register indexes, verdict codes and sizing constants.
// No dependencies.
package lobp_pkg;

  localparam int VALUE_WIDTH        = 32;
  localparam int MAX_LENGTH_DEFAULT = 256;
  localparam int CFG_W              = 9;
  localparam int CFG_IDX_W          = 2;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_X_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRICT_ORDER = 2'd2;

  localparam logic [1:0] VERDICT_NEXT   = 2'd0;
  localparam logic [1:0] VERDICT_SAT    = 2'd1;
  localparam logic [1:0] VERDICT_CONTRA = 2'd2;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic   restart;
    value_t x_low;
    value_t x_high;
    value_t y_low;
    value_t y_high;
  } lobp_in_t;

  typedef struct packed {
    value_t     new_x_high;
    value_t     new_y_low;
    logic       x_high_narrowed;
    logic       y_low_narrowed;
    logic [1:0] verdict;
  } lobp_out_t;

  // classified word: raw bounds plus the compares for slack 0 and slack 1
  typedef struct packed {
    logic   restart;
    value_t x_low;
    value_t x_high;
    value_t y_low;
    value_t y_high;
    value_t y_high_m1;
    value_t x_low_p1;
    logic   xl_gt_yh;
    logic   xl_ge_yh;
    logic   xh_gt_yh;
    logic   xh_ge_yh;
    logic   yl_lt_xl;
    logic   yl_le_xl;
  } lobp_cls_t;

endpackage

// ----- sv/lobp_front.sv -----
// Front end: accepts input words and classifies them for the back end.
// Precomputes all bound compares for both slack values.
// Depends on lobp_pkg.
module lobp_front (
  input  logic              in_valid,
  input  lobp_pkg::lobp_in_t in_word,
  input  logic              q_ready,
  output logic              in_ready,
  output logic              q_write,
  output lobp_pkg::lobp_cls_t q_word
);
  import lobp_pkg::*;

  assign in_ready = q_ready;
  assign q_write  = in_valid & q_ready;

  always_comb begin
    q_word.restart   = in_word.restart;
    q_word.x_low     = in_word.x_low;
    q_word.x_high    = in_word.x_high;
    q_word.y_low     = in_word.y_low;
    q_word.y_high    = in_word.y_high;
    q_word.y_high_m1 = in_word.y_high - value_t'(1);
    q_word.x_low_p1  = in_word.x_low + value_t'(1);
    q_word.xl_gt_yh  = in_word.x_low > in_word.y_high;
    q_word.xl_ge_yh  = in_word.x_low >= in_word.y_high;
    q_word.xh_gt_yh  = in_word.x_high > in_word.y_high;
    q_word.xh_ge_yh  = in_word.x_high >= in_word.y_high;
    q_word.yl_lt_xl  = in_word.y_low < in_word.x_low;
    q_word.yl_le_xl  = in_word.y_low <= in_word.x_low;
  end

endmodule

// ----- sv/lobp_queue.sv -----
// Short register queue between front and back end.
// DEPTH must be a power of two. Depends on lobp_pkg.
module lobp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lobp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             wr_ready,
  input  logic             rd,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import lobp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- sv/lobp_back.sv -----
// Back end: walk state, narrowing, verdict and output register.
// Takes classified words from the queue. Depends on lobp_pkg.
module lobp_back #(
  parameter int MAX_LENGTH = lobp_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [lobp_pkg::CFG_W-1:0] x_length,
  input  logic [lobp_pkg::CFG_W-1:0] y_length,
  input  logic                    strict_order,
  input  logic                    q_valid,
  input  lobp_pkg::lobp_cls_t     q_word,
  output logic                    q_read,
  output logic                    out_valid,
  input  logic                    out_ready,
  output lobp_pkg::lobp_out_t     out_word
);
  import lobp_pkg::*;

  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int CW    = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  logic [LEN_W-1:0] position, position_next;
  logic             stopped, stopped_next;
  logic [1:0]       held, held_next;
  lobp_out_t        res;

  logic [CW-1:0]    x_ext, y_ext;
  logic [LEN_W-1:0] nx, ny, nmin;
  logic [1:0]       len_verdict;
  logic             slack_ok;
  logic [LEN_W-1:0] pos_e;
  logic [LEN_W:0]   pos_inc;
  logic             stop_e;
  logic [1:0]       held_e;
  logic             slack, contra, narrow_x, narrow_y;
  value_t           xh_f, yl_f;
  logic [1:0]       verdict;

  always_comb begin
    x_ext = CW'(x_length);
    y_ext = CW'(y_length);
    if (x_ext == '0) begin
      nx = LEN_W'(1);
    end else if (x_ext > CW'(MAX_LENGTH)) begin
      nx = LEN_W'(MAX_LENGTH);
    end else begin
      nx = LEN_W'(x_ext);
    end
    if (y_ext == '0) begin
      ny = LEN_W'(1);
    end else if (y_ext > CW'(MAX_LENGTH)) begin
      ny = LEN_W'(MAX_LENGTH);
    end else begin
      ny = LEN_W'(y_ext);
    end
    nmin = (nx < ny) ? nx : ny;
    priority if (nx < ny) begin
      len_verdict = VERDICT_SAT;
    end else if (nx > ny) begin
      len_verdict = VERDICT_CONTRA;
    end else begin
      len_verdict = strict_order ? VERDICT_CONTRA : VERDICT_SAT;
    end
    slack_ok = (nx > ny) || (nx == ny && strict_order);
  end

  assign q_read = q_valid && (!out_valid || out_ready);

  always_comb begin
    pos_e   = q_word.restart ? '0 : position;
    stop_e  = q_word.restart ? 1'b0 : stopped;
    held_e  = q_word.restart ? VERDICT_NEXT : held;
    pos_inc = {1'b0, pos_e} + (LEN_W + 1)'(1);
    slack   = (pos_inc == {1'b0, nmin}) && slack_ok;

    contra   = slack ? q_word.xl_ge_yh : q_word.xl_gt_yh;
    narrow_x = slack ? q_word.xh_ge_yh : q_word.xh_gt_yh;
    narrow_y = slack ? q_word.yl_le_xl : q_word.yl_lt_xl;
    xh_f     = narrow_x ? (slack ? q_word.y_high_m1 : q_word.y_high) : q_word.x_high;
    yl_f     = narrow_y ? (slack ? q_word.x_low_p1 : q_word.x_low) : q_word.y_low;

    res.new_x_high      = q_word.x_high;
    res.new_y_low       = q_word.y_low;
    res.x_high_narrowed = 1'b0;
    res.y_low_narrowed  = 1'b0;
    position_next       = pos_e;
    verdict             = VERDICT_SAT;

    priority if (stop_e) begin
      verdict = held_e;
    end else if (pos_e >= nmin) begin
      verdict = len_verdict;
    end else if (contra) begin
      verdict = VERDICT_CONTRA;
    end else begin
      res.new_x_high      = xh_f;
      res.new_y_low       = yl_f;
      res.x_high_narrowed = narrow_x;
      res.y_low_narrowed  = narrow_y;
      if (xh_f < yl_f) begin
        verdict = VERDICT_SAT;
      end else if (q_word.x_low == xh_f && yl_f == q_word.y_high
                   && q_word.x_low == yl_f) begin
        position_next = LEN_W'(pos_inc);
        verdict = (pos_inc >= {1'b0, nmin}) ? len_verdict : VERDICT_NEXT;
      end else begin
        verdict = VERDICT_SAT;
      end
    end
    res.verdict = verdict;

    stopped_next = stop_e || (verdict != VERDICT_NEXT);
    held_next    = (verdict != VERDICT_NEXT) ? verdict : held_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      stopped   <= 1'b0;
      held      <= VERDICT_NEXT;
      out_valid <= 1'b0;
    end else begin
      if (q_read) begin
        position  <= position_next;
        stopped   <= stopped_next;
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_read) begin
      out_word <= res;
    end
  end

endmodule

// ----- sv/lex_order_bounds_propagator.sv -----
// Top level of the lexicographic order bounds propagator.
// Holds the configuration registers; instantiates front, queue and back.
// Depends on lobp_pkg, lobp_front, lobp_queue, lobp_back.
//
// Streams one pair of x/y bounds per word and returns one result word per
// input word, in order. A word is registered on its way from input to output
// (front classifies into a two-entry queue, back end registers the result)
// and one word per cycle is sustained while out_ready is high; the back end's
// walk-state update loop sets that rate. Configuration is written through
// cfg_write/cfg_index/cfg_data and must only change while no word is in flight.
module lex_order_bounds_propagator #(
  parameter int MAX_LENGTH = lobp_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lobp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lobp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lobp_pkg::lobp_in_t            in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lobp_pkg::lobp_out_t           out_word
);
  import lobp_pkg::*;

  logic [CFG_W-1:0] x_length;
  logic [CFG_W-1:0] y_length;
  logic             strict_order;

  logic      q_write, q_ready, q_read, q_valid;
  lobp_cls_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_length     <= CFG_W'(1);
      y_length     <= CFG_W'(1);
      strict_order <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_LENGTH:     x_length     <= cfg_data;
        REG_Y_LENGTH:     y_length     <= cfg_data;
        REG_STRICT_ORDER: strict_order <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lobp_front u_front (
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_ready  (q_ready),
    .in_ready (in_ready),
    .q_write  (q_write),
    .q_word   (q_in)
  );

  lobp_queue #(
    .WIDTH ($bits(lobp_cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_write),
    .wr_data  (q_in),
    .wr_ready (q_ready),
    .rd       (q_read),
    .rd_valid (q_valid),
    .rd_data  (q_out)
  );

  lobp_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .x_length     (x_length),
    .y_length     (y_length),
    .strict_order (strict_order),
    .q_valid      (q_valid),
    .q_word       (q_out),
    .q_read       (q_read),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word)
  );

endmodule

// ----- sim/lex_order_bounds_propagator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lex_order_bounds_propagator: directed and random x/y bound walks.
// Predicts every result word in-line and checks it in order; depends on lobp_pkg and the RTL.
module lex_order_bounds_propagator_tb;
  import lobp_pkg::*;

  localparam int     MAX_LEN = MAX_LENGTH_DEFAULT;
  localparam longint VMIN    = -(longint'(1) << (VALUE_WIDTH - 1));
  localparam longint VMAX    = (longint'(1) << (VALUE_WIDTH - 1)) - 1;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_X_LENGTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  lobp_in_t         in_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  lobp_out_t        out_word;

  // predictor copy of registers and walk state
  logic [CFG_W-1:0] x_len_cfg = 9'd1;
  logic [CFG_W-1:0] y_len_cfg = 9'd1;
  bit               strict_cfg = 1'b0;
  int               walk_pos = 0;
  bit               walk_done = 1'b0;
  logic [1:0]       walk_verdict = VERDICT_NEXT;

  lobp_out_t pending_results[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rx_cycle = 0;
  int hold_end = 0;

  lex_order_bounds_propagator uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("lex_order_bounds_propagator verification failed");
    $finish;
  end

  function automatic int eff_len(input logic [CFG_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_LEN) return MAX_LEN;
    return int'(n);
  endfunction

  function automatic logic [1:0] order_by_length(input int nx, input int ny);
    if (nx < ny) return VERDICT_SAT;
    if (nx > ny) return VERDICT_CONTRA;
    return strict_cfg ? VERDICT_CONTRA : VERDICT_SAT;
  endfunction

  function automatic lobp_out_t tighten_bounds(input lobp_in_t w);
    longint xl, xh, yl, yh, sl;
    int nx, ny, nmin;
    logic [1:0] v;
    lobp_out_t r;
    xl = w.x_low;
    xh = w.x_high;
    yl = w.y_low;
    yh = w.y_high;
    nx = eff_len(x_len_cfg);
    ny = eff_len(y_len_cfg);
    nmin = (nx < ny) ? nx : ny;
    if (w.restart) begin
      walk_pos = 0;
      walk_done = 1'b0;
      walk_verdict = VERDICT_NEXT;
    end
    r.new_x_high = w.x_high;
    r.new_y_low = w.y_low;
    r.x_high_narrowed = 1'b0;
    r.y_low_narrowed = 1'b0;
    if (walk_done) begin
      r.verdict = walk_verdict;
    end else if (walk_pos >= nmin) begin
      v = order_by_length(nx, ny);
      walk_done = 1'b1;
      walk_verdict = v;
      r.verdict = v;
    end else begin
      sl = (walk_pos + 1 == nmin && (nx > ny || (nx == ny && strict_cfg))) ? 1 : 0;
      if (xl > yh - sl) begin
        v = VERDICT_CONTRA;
      end else begin
        if (xh > yh - sl) begin
          xh = yh - sl;
          r.x_high_narrowed = 1'b1;
        end
        if (yl < xl + sl) begin
          yl = xl + sl;
          r.y_low_narrowed = 1'b1;
        end
        if (xh < yl) begin
          v = VERDICT_SAT;
        end else if (xl == xh && yl == yh && xl == yl) begin
          walk_pos++;
          v = (walk_pos >= nmin) ? order_by_length(nx, ny) : VERDICT_NEXT;
        end else begin
          v = VERDICT_SAT;
        end
        r.new_x_high = value_t'(xh);
        r.new_y_low = value_t'(yl);
      end
      if (v != VERDICT_NEXT) begin
        walk_done = 1'b1;
        walk_verdict = v;
      end
      r.verdict = v;
    end
    return r;
  endfunction

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle < hold_end) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    lobp_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word %p", $time, out_word);
      end else begin
        want = pending_results.pop_front();
        if (out_word !== want) begin
          mismatch_count++;
          $display("%0t: mismatch expected x_high=%0d y_low=%0d narrowed=%b%b verdict=%0d",
                   $time, want.new_x_high, want.new_y_low, want.x_high_narrowed,
                   want.y_low_narrowed, want.verdict);
          $display("%0t:          actual   x_high=%0d y_low=%0d narrowed=%b%b verdict=%0d",
                   $time, out_word.new_x_high, out_word.new_y_low,
                   out_word.x_high_narrowed, out_word.y_low_narrowed, out_word.verdict);
        end
      end
    end
  end

  task automatic send_word(input lobp_in_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(tighten_bounds(w));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input int nx, input int ny, input bit st);
    cfg_write <= 1'b1;
    cfg_index <= REG_X_LENGTH;
    cfg_data <= CFG_W'(nx);
    @(posedge clk);
    cfg_index <= REG_Y_LENGTH;
    cfg_data <= CFG_W'(ny);
    @(posedge clk);
    cfg_index <= REG_STRICT_ORDER;
    cfg_data <= CFG_W'(st);
    @(posedge clk);
    cfg_write <= 1'b0;
    x_len_cfg = CFG_W'(nx);
    y_len_cfg = CFG_W'(ny);
    strict_cfg = st;
  endtask

  function automatic lobp_in_t make_word(input bit r, input int xl, input int xh,
                                         input int yl, input int yh);
    lobp_in_t w;
    w.restart = r;
    w.x_low = xl;
    w.x_high = xh;
    w.y_low = yl;
    w.y_high = yh;
    return w;
  endfunction

  function automatic int pick_value();
    case ($urandom_range(9))
      0: return int'(32'h8000_0000 + $urandom_range(2));
      1: return int'(32'h7fff_ffff - $urandom_range(2));
      2, 3, 4, 5: return int'($urandom_range(16)) - 8;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int near(input longint base, input int spread);
    longint t;
    t = base + longint'($urandom_range(2 * spread)) - spread;
    if (t < VMIN) t = VMIN;
    if (t > VMAX) t = VMAX;
    return int'(t);
  endfunction

  function automatic int pick_length();
    case ($urandom_range(15))
      0: return 0;
      1: return MAX_LEN;
      2: return 511;
      3: return $urandom_range(MAX_LEN + 1, 511);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic lobp_in_t random_word(input bit r);
    return make_word(r, pick_value(), pick_value(), pick_value(), pick_value());
  endfunction

  // the pair that ends a walk: loose, tight, ordered or nearly fixed bounds
  function automatic lobp_in_t decisive_pair(input bit first);
    int base, xl, yl;
    base = pick_value();
    xl = near(base, 5);
    yl = near(base, 5);
    case ($urandom_range(3))
      0: return random_word(first);
      1: return make_word(first, near(base, 4), near(base, 6), near(base, 4), near(base, 6));
      2: return make_word(first, xl, near(longint'(xl) + 3, 3), yl, near(longint'(yl) + 3, 3));
      default: return make_word(first, base, base, near(base, 1), near(base, 1));
    endcase
  endfunction

  task automatic run_walks(input int n_words);
    int sent, steps, nmin, v, extra;
    sent = 0;
    nmin = eff_len(x_len_cfg) < eff_len(y_len_cfg) ? eff_len(x_len_cfg) : eff_len(y_len_cfg);
    while (sent < n_words) begin
      if ($urandom_range(99) < 85) begin
        steps = ($urandom_range(9) == 0) ? nmin : $urandom_range(0, nmin < 6 ? nmin : 6);
        for (int i = 0; i < steps; i++) begin
          if ($urandom_range(99) < 3) wait_drain();
          v = pick_value();
          send_word(make_word(i == 0, v, v, v, v));
        end
        send_word(decisive_pair(steps == 0));
        extra = $urandom_range(0, 2);
        repeat (extra) send_word(random_word(1'b0));
        sent += steps + 1 + extra;
      end else begin
        send_word(random_word($urandom_range(1)));
        sent++;
      end
    end
  endtask

  // reset values of the registers: single shared position, non-strict
  task automatic test_single_position();
    send_word(make_word(1'b1, 5, 5, 5, 5));
    send_word(random_word(1'b0));
  endtask

  task automatic test_bound_extremes();
    int vmin, vmax;
    vmin = int'(VMIN);
    vmax = int'(VMAX);
    wait_drain();
    write_config(1, 1, 1'b1);
    send_word(make_word(1'b1, vmax, vmax, vmax, vmax));
    send_word(make_word(1'b1, vmin, vmin, vmin, vmin));
    send_word(random_word(1'b0));
    wait_drain();
    write_config(1, 1, 1'b0);
    send_word(make_word(1'b1, vmin, vmax, vmin, vmax));
    send_word(make_word(1'b1, vmax, vmin, vmax, vmin));
    send_word(make_word(1'b1, -5, 30, -10, 20));
    send_word(make_word(1'b1, 10, 20, 0, 5));
    send_word(make_word(1'b1, 0, 3, 7, 9));
  endtask

  task automatic test_length_order();
    wait_drain();
    write_config(3, 2, 1'b0);
    send_word(make_word(1'b1, 7, 7, 7, 7));
    send_word(make_word(1'b0, int'(VMIN), int'(VMAX), int'(VMIN), int'(VMAX)));
    wait_drain();
    write_config(2, 3, 1'b1);
    send_word(make_word(1'b1, 1, 1, 1, 1));
    send_word(make_word(1'b0, 2, 2, 2, 2));
    wait_drain();
    write_config(2, 2, 1'b1);
    send_word(make_word(1'b1, 3, 3, 3, 3));
    send_word(make_word(1'b0, 4, 4, 4, 4));
  endtask

  task automatic test_restart_mid_walk();
    wait_drain();
    write_config(4, 4, 1'b0);
    send_word(make_word(1'b1, 1, 1, 1, 1));
    send_word(make_word(1'b0, 2, 2, 2, 2));
    send_word(make_word(1'b1, 9, 9, 9, 9));
  endtask

  // lengths shrink under a walk in progress, then clamp at both ends
  task automatic test_beyond_shared_part();
    wait_drain();
    write_config(4, 4, 1'b0);
    send_word(make_word(1'b1, 6, 6, 6, 6));
    send_word(make_word(1'b0, -3, -3, -3, -3));
    wait_drain();
    write_config(2, 3, 1'b0);
    send_word(make_word(1'b0, 50, 10, -7, 100));
    wait_drain();
    write_config(511, 0, 1'b1);
    send_word(make_word(1'b1, 2, 2, 2, 2));
  endtask

  task automatic test_backpressure();
    int saved_pct, v;
    saved_pct = send_idle_pct;
    wait_drain();
    write_config(MAX_LEN, MAX_LEN, 1'b0);
    send_idle_pct = 0;
    hold_end = rx_cycle + 200;
    for (int i = 0; i < 40; i++) begin
      v = pick_value();
      send_word(make_word(i == 0, v, v, v, v));
    end
    wait_drain();
    send_idle_pct = saved_pct;
  endtask

  task automatic test_random_walks();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 37 : 0;
      for (int s = 0; s < 8; s++) begin
        wait_drain();
        write_config(pick_length(), pick_length(), $urandom_range(1));
        run_walks(70);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 45;
    test_single_position();
    test_bound_extremes();
    test_length_order();
    test_restart_mid_walk();
    test_beyond_shared_part();
    test_backpressure();
    test_random_walks();
    wait_drain();
    if (mismatch_count == 0) $display("lex_order_bounds_propagator verification clean");
    else $display("lex_order_bounds_propagator verification failed");
    $finish;
  end

endmodule
